FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLKD(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: hw/rtl/slc_pkg.sv
// Types and constants of the stepper leveling controller.
`timescale 1ns / 1ps
package slc_pkg;

    localparam logic [5:0]  POS_MAX    = 6'd63;
    localparam logic [5:0]  POS_CENTER = 6'd32;
    localparam logic [11:0] STUCK_SAT  = 12'd4095;
    localparam logic [3:0]  RETRY_SAT  = 4'd15;

    localparam logic [11:0] RST_STUCK_TIMEOUT = 12'd100;
    localparam logic [3:0]  RST_RETRY_LIMIT   = 4'd3;
    localparam logic [7:0]  RST_FULL_TRAVEL   = 8'd64;
    localparam logic [7:0]  RST_CENTERING     = 8'd32;

    typedef enum logic [1:0] {
        CFG_STUCK_TIMEOUT = 2'd0,
        CFG_RETRY_LIMIT   = 2'd1,
        CFG_FULL_TRAVEL   = 2'd2,
        CFG_CENTERING     = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_MIN_REQ  = 3'd0,
        PH_MIN_WAIT = 3'd1,
        PH_MAX_REQ  = 3'd2,
        PH_MAX_WAIT = 3'd3,
        PH_CTR_REQ  = 3'd4,
        PH_CTR_WAIT = 3'd5,
        PH_TRACK    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [11:0] stuck_timeout_ticks;
        logic [3:0]  retry_limit;
        logic [7:0]  full_travel_steps;
        logic [7:0]  centering_steps;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        phase_t      previous_phase;
        logic [11:0] stuck_count;
        logic [3:0]  retry_count;
        logic        awaiting_move;
        logic [5:0]  believed_position;
        logic [5:0]  goal_position;
        logic [5:0]  pending_position;
        logic        auto_flag;
    } state_t;

    typedef struct packed {
        logic       motor_idle;
        logic [7:0] manual_level;
        logic [7:0] sensor_level;
        logic       auto_request;
    } item_t;

    typedef struct packed {
        logic       move_cmd;
        logic       move_up;
        logic [7:0] move_steps;
        logic [5:0] position_now;
        logic [5:0] position_goal;
        logic       auto_active;
        logic       referenced;
        logic       halted;
    } result_t;

endpackage

FILE: hw/rtl/slc_step.sv
// Per-tick next-state and result logic of the leveling controller.
`timescale 1ns / 1ps
module slc_step (
    input  slc_pkg::state_t  st,
    input  slc_pkg::cfg_t    cfg,
    input  slc_pkg::item_t   item,
    output slc_pkg::state_t  st_next,
    output slc_pkg::result_t res
);
    import slc_pkg::*;

    state_t     s;
    logic       halted;
    logic       cmd_valid;
    logic       cmd_up;
    logic [7:0] cmd_steps;
    logic [7:0] level;
    logic [5:0] goal;

    always_comb
    begin
        s         = st;
        cmd_valid = 1'b0;
        cmd_up    = 1'b0;
        cmd_steps = 8'd0;
        level     = item.auto_request ? item.sensor_level : item.manual_level;
        goal      = (level > {2'b00, POS_MAX}) ? POS_MAX : level[5:0];

        // timeout restarts referencing
        if (s.stuck_count >= cfg.stuck_timeout_ticks)
        begin
            s.phase         = PH_MIN_REQ;
            s.awaiting_move = 1'b0;
            s.stuck_count   = 12'd0;
            if (s.retry_count < RETRY_SAT)
                s.retry_count = s.retry_count + 4'd1;
        end

        halted = (s.retry_count >= cfg.retry_limit);

        if (!halted)
        begin
            if (s.phase != PH_TRACK)
            begin
                case (s.phase)
                    PH_MIN_REQ:
                        if (item.motor_idle)
                        begin
                            cmd_valid = 1'b1;
                            cmd_steps = cfg.full_travel_steps;
                            s.phase   = PH_MIN_WAIT;
                        end
                    PH_MIN_WAIT:
                        if (item.motor_idle)
                        begin
                            s.believed_position = 6'd0;
                            s.phase             = PH_MAX_REQ;
                        end
                    PH_MAX_REQ:
                        if (item.motor_idle)
                        begin
                            cmd_valid = 1'b1;
                            cmd_up    = 1'b1;
                            cmd_steps = cfg.full_travel_steps;
                            s.phase   = PH_MAX_WAIT;
                        end
                    PH_MAX_WAIT:
                        if (item.motor_idle)
                        begin
                            s.believed_position = POS_MAX;
                            s.phase             = PH_CTR_REQ;
                        end
                    PH_CTR_REQ:
                        if (item.motor_idle)
                        begin
                            cmd_valid = 1'b1;
                            cmd_steps = cfg.centering_steps;
                            s.phase   = PH_CTR_WAIT;
                        end
                    PH_CTR_WAIT:
                        if (item.motor_idle)
                        begin
                            s.believed_position = POS_CENTER;
                            s.goal_position     = POS_CENTER;
                            s.pending_position  = POS_CENTER;
                            s.phase             = PH_TRACK;
                        end
                    default:
                        s.phase = PH_TRACK;
                endcase
                if (s.phase != PH_TRACK && s.phase == s.previous_phase)
                begin
                    if (s.stuck_count < STUCK_SAT)
                        s.stuck_count = s.stuck_count + 12'd1;
                end
                else
                begin
                    s.stuck_count = 12'd0;
                end
                s.previous_phase = s.phase;
            end
            else if (item.motor_idle)
            begin
                if (s.awaiting_move)
                begin
                    s.believed_position = s.pending_position;
                    s.awaiting_move     = 1'b0;
                end
                else
                begin
                    s.auto_flag     = item.auto_request;
                    s.goal_position = goal;
                    if (goal != s.believed_position)
                    begin
                        cmd_valid = 1'b1;
                        if (goal > s.believed_position)
                        begin
                            cmd_up    = 1'b1;
                            cmd_steps = {2'b00, goal - s.believed_position};
                        end
                        else
                        begin
                            cmd_steps = {2'b00, s.believed_position - goal};
                        end
                        s.pending_position = goal;
                        s.awaiting_move    = 1'b1;
                    end
                end
            end
        end

        st_next           = s;
        res.move_cmd      = cmd_valid;
        res.move_up       = cmd_up;
        res.move_steps    = cmd_steps;
        res.position_now  = s.believed_position;
        res.position_goal = s.goal_position;
        res.auto_active   = s.auto_flag;
        res.referenced    = (s.phase == PH_TRACK);
        res.halted        = halted;
    end

endmodule

FILE: hw/rtl/stepper_leveling_controller_unit.sv
// Top level of the stepper leveling controller.
// Each input transaction is one control tick and yields exactly one result
// transaction in the next cycle. A tick is taken in every cycle in which the
// result register is empty or being drained, so the sustained rate is one
// tick per clock, as the state update that feeds the state registers and the
// result register is combinational. Configuration is written through the cfg
// port (index 0 timeout, 1 retry limit, 2 full travel steps, 3 centering
// steps) and is always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stepper_leveling_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // motor_idle, manual_level[7:0], sensor_level[7:0], zero pad
    input  logic [0:0]  s_tuser,   // auto_request
    output logic        m_tvalid,
    input  logic        m_tready,
    // move_cmd, move_up, move_steps[7:0], position_now[5:0],
    // position_goal[5:0], auto_active, referenced, halted, zero pad
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import slc_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item;
    result_t res;
    logic    m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic    accept;

    assign item.motor_idle   = s_tdata[0];
    assign item.manual_level = s_tdata[8:1];
    assign item.sensor_level = s_tdata[16:9];
    assign item.auto_request = s_tuser[0];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    slc_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (item),
        .st_next (state_next),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stuck_timeout_ticks <= RST_STUCK_TIMEOUT;
            cfg_reg.retry_limit         <= RST_RETRY_LIMIT;
            cfg_reg.full_travel_steps   <= RST_FULL_TRAVEL;
            cfg_reg.centering_steps     <= RST_CENTERING;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_STUCK_TIMEOUT: cfg_reg.stuck_timeout_ticks <= cfg_data;
                CFG_RETRY_LIMIT:   cfg_reg.retry_limit         <= cfg_data[3:0];
                CFG_FULL_TRAVEL:   cfg_reg.full_travel_steps   <= cfg_data[7:0];
                CFG_CENTERING:     cfg_reg.centering_steps     <= cfg_data[7:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase             <= PH_MIN_REQ;
            state_reg.previous_phase    <= PH_MIN_REQ;
            state_reg.stuck_count       <= 12'd0;
            state_reg.retry_count       <= 4'd0;
            state_reg.awaiting_move     <= 1'b0;
            state_reg.believed_position <= POS_CENTER;
            state_reg.goal_position     <= POS_CENTER;
            state_reg.pending_position  <= POS_CENTER;
            state_reg.auto_flag         <= 1'b0;
            m_tvalid_reg                <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= {7'd0, res.halted, res.referenced, res.auto_active,
                            res.position_goal, res.position_now, res.move_steps,
                            res.move_up, res.move_cmd};
    end

    `ASSERT_CLKD(a_accept_gives_result, clk, rst_n, accept |=> m_tvalid, "tick lost")
    `ASSERT_CLKD(a_wait_only_tracking, clk, rst_n,
        state_reg.awaiting_move |-> (state_reg.phase == PH_TRACK), "pending move outside tracking")
    `ASSERT_CLKD(a_no_stuck_in_track, clk, rst_n,
        (state_reg.phase == PH_TRACK) |-> (state_reg.stuck_count == 12'd0),
        "stuck timer running while tracking")
    `ASSERT_NEVER(a_halted_no_move, clk, rst_n, m_tvalid && m_tdata[24] && m_tdata[0],
        "move issued while halted")

endmodule
